[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WIA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define WIA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define WIA_ASSERT(lbl, clk, rst, prop)
`define WIA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/wia_pkg.sv]
package wia_pkg;

   localparam int unsigned XLEN = 64;

   localparam logic [4:0] FN_ADD    = 5'd0;
   localparam logic [4:0] FN_SUB    = 5'd1;
   localparam logic [4:0] FN_MUL    = 5'd2;
   localparam logic [4:0] FN_AND    = 5'd3;
   localparam logic [4:0] FN_OR     = 5'd4;
   localparam logic [4:0] FN_XOR    = 5'd5;
   localparam logic [4:0] FN_ROTL   = 5'd6;
   localparam logic [4:0] FN_ROTR   = 5'd7;
   localparam logic [4:0] FN_DIV_S  = 5'd8;
   localparam logic [4:0] FN_DIV_U  = 5'd9;
   localparam logic [4:0] FN_REM_S  = 5'd10;
   localparam logic [4:0] FN_REM_U  = 5'd11;
   localparam logic [4:0] FN_SHL    = 5'd12;
   localparam logic [4:0] FN_SHR_S  = 5'd13;
   localparam logic [4:0] FN_SHR_U  = 5'd14;
   localparam logic [4:0] FN_EQ     = 5'd15;
   localparam logic [4:0] FN_NE     = 5'd16;
   localparam logic [4:0] FN_LT_S   = 5'd17;
   localparam logic [4:0] FN_LT_U   = 5'd18;
   localparam logic [4:0] FN_LE_S   = 5'd19;
   localparam logic [4:0] FN_LE_U   = 5'd20;
   localparam logic [4:0] FN_GT_S   = 5'd21;
   localparam logic [4:0] FN_GT_U   = 5'd22;
   localparam logic [4:0] FN_GE_S   = 5'd23;
   localparam logic [4:0] FN_GE_U   = 5'd24;
   localparam logic [4:0] FN_CLZ    = 5'd25;
   localparam logic [4:0] FN_CTZ    = 5'd26;
   localparam logic [4:0] FN_POPCNT = 5'd27;
   localparam logic [4:0] FN_EQZ    = 5'd28;

   localparam logic [1:0] TRAP_NONE     = 2'd0;
   localparam logic [1:0] TRAP_DIV_ZERO = 2'd1;
   localparam logic [1:0] TRAP_OVERFLOW = 2'd2;

   typedef enum logic [1:0] {
      OC_FAST,
      OC_MUL,
      OC_COUNT,
      OC_DIV
   } op_class_type;

   typedef struct packed {
      logic [4:0]   func;
      logic         wide;
      op_class_type op_class;
      logic         neg_q;
      logic         neg_r;
      logic [1:0]   trap;
      logic [63:0]  opa;
      logic [63:0]  opb;
      logic [63:0]  mag_a;
      logic [63:0]  mag_b;
   } wia_item_type;

   function automatic logic [63:0] width_mask(input logic wide);
      return wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
   endfunction

endpackage

[rtl/wia_if.sv]
interface wia_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  func;
   logic        is_wide;
   logic [63:0] operand_a;
   logic [63:0] operand_b;

   modport source (output valid, output func, output is_wide, output operand_a,
                   output operand_b, input ready);
   modport sink (input valid, input func, input is_wide, input operand_a,
                 input operand_b, output ready);
endinterface

interface wia_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [1:0]  trap_code;

   modport source (output valid, output value, output trap_code, input ready);
   modport sink (input valid, input value, input trap_code, output ready);
endinterface

[rtl/wia_front.sv]
module wia_front import wia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   wia_req_if.sink      req,
   output logic         out_valid,
   input  logic         out_ready,
   output wia_item_type out_item
);

   logic         front_valid_ff, front_valid_in;
   wia_item_type item_ff, item_in;
   logic         take;

   logic [63:0] m, a, b, sa, sb, sbit;
   logic        na, nb, ovf, is_div, signed_div;

   assign req.ready = !front_valid_ff || out_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      m    = width_mask(req.is_wide);
      a    = req.operand_a & m;
      b    = req.operand_b & m;
      na   = req.is_wide ? a[63] : a[31];
      nb   = req.is_wide ? b[63] : b[31];
      sa   = req.is_wide ? a : {{32{a[31]}}, a[31:0]};
      sb   = req.is_wide ? b : {{32{b[31]}}, b[31:0]};
      sbit = req.is_wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
      ovf  = (a == sbit) && (b == m);
      is_div = (req.func == FN_DIV_S) || (req.func == FN_DIV_U) ||
               (req.func == FN_REM_S) || (req.func == FN_REM_U);
      signed_div = (req.func == FN_DIV_S) || (req.func == FN_REM_S);

      item_in.func  = req.func;
      item_in.wide  = req.is_wide;
      item_in.opa   = a;
      item_in.opb   = b;
      item_in.mag_a = (signed_div && na) ? 64'd0 - sa : a;
      item_in.mag_b = (signed_div && nb) ? 64'd0 - sb : b;
      item_in.neg_q = (req.func == FN_DIV_S) && (na ^ nb);
      item_in.neg_r = (req.func == FN_REM_S) && na;

      // zero divisor wins over overflow
      if (is_div && (b == 64'd0)) begin
         item_in.trap = TRAP_DIV_ZERO;
      end else if ((req.func == FN_DIV_S) && ovf) begin
         item_in.trap = TRAP_OVERFLOW;
      end else begin
         item_in.trap = TRAP_NONE;
      end

      if (is_div) begin
         item_in.op_class = OC_DIV;
      end else if (req.func == FN_MUL) begin
         item_in.op_class = OC_MUL;
      end else if ((req.func == FN_CLZ) || (req.func == FN_CTZ) ||
                   (req.func == FN_POPCNT)) begin
         item_in.op_class = OC_COUNT;
      end else begin
         item_in.op_class = OC_FAST;
      end
   end

   always_comb begin
      if (take) begin
         front_valid_in = 1'b1;
      end else if (out_ready) begin
         front_valid_in = 1'b0;
      end else begin
         front_valid_in = front_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = front_valid_ff;
   assign out_item  = item_ff;

endmodule

[rtl/wia_queue.sv]
`include "assert_macros.svh"

module wia_queue import wia_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  wia_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output wia_item_type pop_item
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   wia_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push_fire, pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_ready && pop_valid;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `WIA_ASSERT(a_cnt_range, clock, reset, count_ff <= CNT_W'(DEPTH))
   `WIA_ASSERT(a_cnt_track, clock, reset, (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + 1'b1))
   `WIA_ASSERT(a_ptr_empty, clock, reset, (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))

endmodule

[rtl/wia_back.sv]
`include "assert_macros.svh"

module wia_back import wia_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   output logic         item_pop,
   input  wia_item_type item,
   wia_rsp_if.source    rsp
);

   localparam int unsigned STEPS = XLEN;

   typedef struct packed {
      logic [4:0]   func;
      logic         wide;
      op_class_type op_class;
      logic         neg_q;
      logic         neg_r;
      logic [1:0]   trap;
      logic [63:0]  res;
      logic [63:0]  rem;
      logic [63:0]  quo;
      logic [63:0]  dvs;
   } stg_type;

   function automatic logic [3:0] byte_lz(input logic [7:0] x);
      logic [3:0] n;
      logic       hit;
      n   = '0;
      hit = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (x[i]) hit = 1'b1;
         if (!hit) n = n + 4'd1;
      end
      return n;
   endfunction

   function automatic logic [3:0] byte_tz(input logic [7:0] x);
      logic [3:0] n;
      logic       hit;
      n   = '0;
      hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (x[i]) hit = 1'b1;
         if (!hit) n = n + 4'd1;
      end
      return n;
   endfunction

   function automatic logic [3:0] byte_pop(input logic [7:0] x);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, x[i]};
      end
      return n;
   endfunction

   // one restoring divide step
   function automatic stg_type div_step(input stg_type s);
      stg_type    o;
      logic [64:0] trial;
      logic [64:0] diff;
      o     = s;
      trial = {s.rem, s.quo[63]};
      diff  = trial - {1'b0, s.dvs};
      if (!diff[64]) begin
         o.rem = diff[63:0];
         o.quo = {s.quo[62:0], 1'b1};
      end else begin
         o.rem = trial[63:0];
         o.quo = {s.quo[62:0], 1'b0};
      end
      return o;
   endfunction

   stg_type          st_ff [STEPS+1];
   stg_type          st_in [STEPS+1];
   logic [STEPS:0]   valid_ff, valid_in;
   logic             advance;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      value_ff, value_in;
   logic [1:0]       trap_ff, trap_in;

   // entry stage operands
   logic [63:0] m, a, b, sa, dup, rl64, rr64, rl32, rr32, sra, ax, bx, fast_res, cnt_src;
   logic [5:0]  sh;
   logic [6:0]  sh7;
   logic [63:0] pll_ff, pll_in;
   logic [31:0] plh_ff, plh_in, phl_ff, phl_in;
   logic [7:0][3:0] lz_ff, lz_in, tz_ff, tz_in, pop_ff, pop_in;

   // second stage combine
   logic [63:0] mul_res, cnt_res;
   logic [6:0]  clz_sum, ctz_sum, pop_sum;
   logic        clz_done, ctz_done;

   // final select
   logic [63:0] fm, qv, rv;

   assign advance  = !rsp_valid_ff || rsp.ready;
   assign item_pop = advance;

   always_comb begin
      m    = width_mask(item.wide);
      a    = item.opa;
      b    = item.opb;
      sh   = item.wide ? b[5:0] : {1'b0, b[4:0]};
      sh7  = {1'b0, sh};
      sa   = item.wide ? a : {{32{a[31]}}, a[31:0]};
      dup  = {a[31:0], a[31:0]};
      rl64 = (a << sh) | (a >> (7'd64 - sh7));
      rr64 = (a >> sh) | (a << (7'd64 - sh7));
      rl32 = dup << sh[4:0];
      rr32 = dup >> sh[4:0];
      sra  = $unsigned($signed(sa) >>> sh) & m;
      ax   = a ^ (item.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000);
      bx   = b ^ (item.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000);

      case (item.func)
         FN_ADD:   fast_res = (a + b) & m;
         FN_SUB:   fast_res = (a - b) & m;
         FN_AND:   fast_res = a & b;
         FN_OR:    fast_res = a | b;
         FN_XOR:   fast_res = a ^ b;
         FN_ROTL:  fast_res = item.wide ? rl64 : {32'd0, rl32[63:32]};
         FN_ROTR:  fast_res = item.wide ? rr64 : {32'd0, rr32[31:0]};
         FN_SHL:   fast_res = (a << sh) & m;
         FN_SHR_S: fast_res = sra;
         FN_SHR_U: fast_res = a >> sh;
         FN_EQ:    fast_res = {63'd0, a == b};
         FN_NE:    fast_res = {63'd0, a != b};
         FN_LT_S:  fast_res = {63'd0, ax < bx};
         FN_LT_U:  fast_res = {63'd0, a < b};
         FN_LE_S:  fast_res = {63'd0, !(bx < ax)};
         FN_LE_U:  fast_res = {63'd0, a <= b};
         FN_GT_S:  fast_res = {63'd0, bx < ax};
         FN_GT_U:  fast_res = {63'd0, a > b};
         FN_GE_S:  fast_res = {63'd0, !(ax < bx)};
         FN_GE_U:  fast_res = {63'd0, a >= b};
         FN_EQZ:   fast_res = {63'd0, a == 64'd0};
         default:  fast_res = 64'd0;
      endcase

      // low 64 bits of the product from three 32x32 partials
      pll_in = a[31:0] * b[31:0];
      plh_in = a[31:0] * b[63:32];
      phl_in = a[63:32] * b[31:0];

      // a stop bit above the low word caps ctz at 32 for narrow ops
      cnt_src = item.wide ? a : (a | 64'h0000_0001_0000_0000);
      for (int j = 0; j < 8; j++) begin
         lz_in[j]  = byte_lz(a[8*j +: 8]);
         tz_in[j]  = byte_tz(cnt_src[8*j +: 8]);
         pop_in[j] = byte_pop(a[8*j +: 8]);
      end
   end

   always_comb begin
      mul_res = (pll_ff + {plh_ff + phl_ff, 32'd0}) & width_mask(st_ff[0].wide);

      clz_sum  = '0;
      clz_done = 1'b0;
      for (int j = 7; j >= 0; j--) begin
         if (!clz_done) begin
            clz_sum = clz_sum + {3'd0, lz_ff[j]};
            if (lz_ff[j] != 4'd8) clz_done = 1'b1;
         end
      end
      ctz_sum  = '0;
      ctz_done = 1'b0;
      for (int j = 0; j < 8; j++) begin
         if (!ctz_done) begin
            ctz_sum = ctz_sum + {3'd0, tz_ff[j]};
            if (tz_ff[j] != 4'd8) ctz_done = 1'b1;
         end
      end
      pop_sum = '0;
      for (int j = 0; j < 8; j++) begin
         pop_sum = pop_sum + {3'd0, pop_ff[j]};
      end

      case (st_ff[0].func)
         FN_CLZ:  cnt_res = {57'd0, st_ff[0].wide ? clz_sum : clz_sum - 7'd32};
         FN_CTZ:  cnt_res = {57'd0, ctz_sum};
         default: cnt_res = {57'd0, pop_sum};
      endcase
   end

   always_comb begin
      st_in[0].func     = item.func;
      st_in[0].wide     = item.wide;
      st_in[0].op_class = item.op_class;
      st_in[0].neg_q    = item.neg_q;
      st_in[0].neg_r    = item.neg_r;
      st_in[0].trap     = item.trap;
      st_in[0].res      = fast_res;
      st_in[0].rem      = 64'd0;
      st_in[0].quo      = item.mag_a;
      st_in[0].dvs      = item.mag_b;
      for (int k = 0; k < STEPS; k++) begin
         st_in[k+1] = div_step(st_ff[k]);
      end
      if (st_ff[0].op_class == OC_MUL) begin
         st_in[1].res = mul_res;
      end else if (st_ff[0].op_class == OC_COUNT) begin
         st_in[1].res = cnt_res;
      end
      valid_in = advance ? {valid_ff[STEPS-1:0], item_valid} : valid_ff;
   end

   always_comb begin
      fm = width_mask(st_ff[STEPS].wide);
      qv = st_ff[STEPS].neg_q ? 64'd0 - st_ff[STEPS].quo : st_ff[STEPS].quo;
      rv = st_ff[STEPS].neg_r ? 64'd0 - st_ff[STEPS].rem : st_ff[STEPS].rem;
      if (st_ff[STEPS].trap != TRAP_NONE) begin
         value_in = 64'd0;
      end else begin
         case (st_ff[STEPS].func)
            FN_DIV_S, FN_DIV_U: value_in = qv & fm;
            FN_REM_S, FN_REM_U: value_in = rv & fm;
            default:            value_in = st_ff[STEPS].res;
         endcase
      end
      trap_in      = st_ff[STEPS].trap;
      rsp_valid_in = advance ? valid_ff[STEPS] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
         pll_ff   <= pll_in;
         plh_ff   <= plh_in;
         phl_ff   <= phl_in;
         lz_ff    <= lz_in;
         tz_ff    <= tz_in;
         pop_ff   <= pop_in;
         value_ff <= value_in;
         trap_ff  <= trap_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.value     = value_ff;
   assign rsp.trap_code = trap_ff;

   `WIA_ASSERT(a_trap_zero, clock, reset, (rsp_valid_ff && (trap_ff != TRAP_NONE)) |-> (value_ff == 64'd0))
   `WIA_ASSERT(a_trap_code, clock, reset, rsp_valid_ff |-> ((trap_ff == TRAP_NONE) || (trap_ff == TRAP_DIV_ZERO) || (trap_ff == TRAP_OVERFLOW)))
   `WIA_ASSERT(a_stall_hold, clock, reset, !advance |=> $stable(valid_ff))
   `WIA_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid_ff)

endmodule

[rtl/wasm_integer_alu_unit.sv]
// channel   dir  handshake          payload
// req_chan  in   valid/ready        func, is_wide, operand_a, operand_b
// rsp_chan  out  valid/ready        value, trap_code
//
// one item per cycle sustained while rsp_chan is ready, every operation
// a req passes the front register, the queue, the 64-step divide pipeline and the rsp register
// synchronous reset clears the valid bits and the queue pointers and count only, no clearing pass
// rsp stall freezes the execute pipeline; the front keeps filling the queue until it is full
module wasm_integer_alu_unit import wia_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   wia_req_if.sink    req_chan,
   wia_rsp_if.source  rsp_chan
);

   logic         fq_valid, fq_ready;
   wia_item_type fq_item;
   logic         qb_valid, qb_pop;
   wia_item_type qb_item;

   wia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   wia_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_pop),
      .pop_item   (qb_item)
   );

   wia_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (qb_valid),
      .item_pop   (qb_pop),
      .item       (qb_item),
      .rsp        (rsp_chan)
   );

endmodule
